### sv/sitda_pkg.sv
// ----------------------------------------------------------------------------
// sitda_pkg: shared types and constants
// Control and status bundles, character codes and the double-dabble step
// used by the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_W       = 32;
  localparam int NUM_DIGITS    = 10;
  localparam int BCD_W         = NUM_DIGITS * 4;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(CONV_STEPS);
  localparam int DIGIT_IDX_W   = $clog2(NUM_DIGITS);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_SIZE  = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } state_t;

  typedef struct packed {
    logic load;
    logic conv;
    logic size;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic conv_done;
    logic digit_last;
    logic out_free;
  } status_t;

  // One shift-and-add-3 step over all BCD digits.
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic bit_in);
    logic [BCD_W-1:0] adj;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

endpackage

### sv/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit: signed 32-bit integer to decimal text
// After a request is accepted, the magnitude is converted at 4 bits per step,
// sized, and the first character, minus sign or digit, is then registered out.
// One character per cycle while the output is not stalled; a new request is
// taken only once the last character of the previous one has been issued.
// Reset: synchronous, clears the state machine and the output valid only.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  character,
  output logic        last_char
);

  sitda_pkg::cmd_t    cmd;
  sitda_pkg::status_t status;

  sitda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sitda_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last_char (last_char)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Unit not busy after accepting a request.");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && character == sitda_pkg::CHAR_MINUS) |-> !last_char)
    else $error("Minus sign flagged as the last character.");

  a_midstring_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_char) |-> in_stall)
    else $error("Unit took a request with characters still pending.");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && character != sitda_pkg::CHAR_MINUS) |->
      (character >= sitda_pkg::CHAR_ZERO && character <= sitda_pkg::CHAR_NINE))
    else $error("Output character is not a digit.");

endmodule

### sv/sitda_ctrl.sv
// ----------------------------------------------------------------------------
// sitda_ctrl: sequencing state machine
// Accepts a request, runs the conversion steps, sizes the result and then
// issues one character per free output slot.
// ----------------------------------------------------------------------------
module sitda_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  sitda_pkg::status_t status,
  output sitda_pkg::cmd_t    cmd
);

  sitda_pkg::state_t state;
  sitda_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sitda_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      sitda_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sitda_pkg::ST_CONV;
        end
      end
      sitda_pkg::ST_CONV: begin
        cmd.conv = 1'b1;
        if (status.conv_done) begin
          state_next = sitda_pkg::ST_SIZE;
        end
      end
      sitda_pkg::ST_SIZE: begin
        cmd.size   = 1'b1;
        state_next = status.neg ? sitda_pkg::ST_SIGN : sitda_pkg::ST_DIGIT;
      end
      sitda_pkg::ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = sitda_pkg::ST_DIGIT;
        end
      end
      sitda_pkg::ST_DIGIT: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.digit_last) begin
            state_next = sitda_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = sitda_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sv/sitda_dp.sv
// ----------------------------------------------------------------------------
// sitda_dp: conversion datapath
// Magnitude register, four-bit-per-cycle binary to BCD conversion, leading
// digit search and the registered character output.
// ----------------------------------------------------------------------------
module sitda_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  sitda_pkg::cmd_t                      cmd,
  output sitda_pkg::status_t                   status,
  input  logic [sitda_pkg::VALUE_W-1:0]        value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [7:0]                           character,
  output logic                                 last_char
);

  logic [sitda_pkg::VALUE_W-1:0]     mag;
  logic [sitda_pkg::BCD_W-1:0]       bcd;
  logic                              neg;
  logic [sitda_pkg::STEP_W-1:0]      step_cnt;
  logic [sitda_pkg::DIGIT_IDX_W-1:0] digit_idx;
  logic [sitda_pkg::BCD_W-1:0]       conv_bcd;
  logic [sitda_pkg::DIGIT_IDX_W-1:0] top_idx;
  logic [3:0]                        cur_digit;

  always_comb begin
    conv_bcd = bcd;
    for (int s = 0; s < sitda_pkg::BITS_PER_STEP; s++) begin
      conv_bcd = sitda_pkg::dabble_step(conv_bcd, mag[sitda_pkg::VALUE_W-1-s]);
    end
  end

  always_comb begin
    top_idx = '0;
    for (int i = 1; i < sitda_pkg::NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        top_idx = sitda_pkg::DIGIT_IDX_W'(i);
      end
    end
  end

  assign cur_digit = bcd[{digit_idx, 2'b00} +: 4];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg      <= value[sitda_pkg::VALUE_W-1];
      mag      <= value[sitda_pkg::VALUE_W-1] ? (~value + 1'b1) : value;
      bcd      <= '0;
      step_cnt <= '0;
    end else if (cmd.conv) begin
      bcd      <= conv_bcd;
      mag      <= mag << sitda_pkg::BITS_PER_STEP;
      step_cnt <= step_cnt + 1'b1;
    end
    if (cmd.size) begin
      digit_idx <= top_idx;
    end else if (cmd.emit_digit) begin
      digit_idx <= digit_idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      character <= sitda_pkg::CHAR_MINUS;
      last_char <= 1'b0;
    end else if (cmd.emit_digit) begin
      character <= sitda_pkg::CHAR_ZERO + {4'd0, cur_digit};
      last_char <= (digit_idx == '0);
    end
  end

  assign status.neg        = neg;
  assign status.conv_done  = (step_cnt == sitda_pkg::STEP_W'(sitda_pkg::CONV_STEPS - 1));
  assign status.digit_last = (digit_idx == '0);
  assign status.out_free   = !out_valid || !out_stall;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: signed integer to decimal text converter
// Feeds 32-bit signed requests through the valid/stall input, predicts the
// decimal character stream of each accepted request and checks every
// character and end-of-text flag in order, under random idling on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  character;
  logic        last_char;

  logic [31:0] pending_values[$];
  text_char_t  expected_text[$];
  int          send_idle_pct = 36;
  int          recv_idle_pct = 59;
  int          phase = 1;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          mismatches = 0;
  int          cycle_count = 0;

  signed_int_to_decimal_ascii_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last_char (last_char)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic void predict_text(input logic [31:0] v);
    logic [31:0] mag;
    logic [3:0]  digs[sitda_pkg::NUM_DIGITS];
    int          nd;
    text_char_t  tc;
    mag = v[31] ? (32'd0 - v) : v;
    nd = 0;
    do begin
      digs[nd] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      nd++;
    end while (mag != 0 && nd < sitda_pkg::NUM_DIGITS);
    if (v[31]) begin
      tc.character = sitda_pkg::CHAR_MINUS;
      tc.last_char = 1'b0;
      expected_text.push_back(tc);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      tc.character = sitda_pkg::CHAR_ZERO + 8'(digs[i]);
      tc.last_char = (i == 0);
      expected_text.push_back(tc);
    end
  endfunction

  function automatic logic [31:0] random_value();
    longint unsigned lim;
    longint unsigned mag;
    int              nd;
    if ($urandom_range(0, 3) == 0) begin
      return $urandom;
    end
    nd = $urandom_range(1, 10);
    lim = 1;
    for (int i = 0; i < nd; i++) begin
      lim = lim * 10;
    end
    mag = {$urandom, $urandom} % lim;
    if ($urandom_range(0, 1) == 1) begin
      if (mag > 64'd2147483648) begin
        mag = 64'd2147483648;
      end
      return 32'd0 - 32'(mag);
    end
    if (mag > 64'd2147483647) begin
      mag = 64'd2147483647;
    end
    return 32'(mag);
  endfunction

  // Driver: holds a stalled request, otherwise offers the next one or idles.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      value <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_text(value);
      end
      if (!in_valid || !in_stall) begin
        if (pending_values.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          value <= pending_values.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted character and decides the next stall.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                    character, last_char));
        end else begin
          text_char_t exp_char;
          exp_char = expected_text.pop_front();
          if (character !== exp_char.character) begin
            report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                      character, exp_char.character));
          end
          if (last_char !== exp_char.last_char) begin
            report_mismatch($sformatf("last_char %0b, expected %0b",
                                      last_char, exp_char.last_char));
          end
        end
      end
      if (phase == 3 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [31:0] directed[] = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
      32'd999999999, -32'sd999999999, 32'd12345, 32'h5555_5555,
      32'hAAAA_AAAA, 32'h0F0F_0F0F, 32'hF0F0_F0F0, -32'sd1000000000
    };
    foreach (directed[i]) begin
      pending_values.push_back(directed[i]);
    end
    for (int i = 0; i < 50; i++) begin
      pending_values.push_back(random_value());
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_values.size() > 0) @(posedge clk);
    send_idle_pct = 59;
    recv_idle_pct = 36;
    phase = 2;
    for (int i = 0; i < 50; i++) begin
      pending_values.push_back(random_value());
    end

    while (pending_values.size() > 0) @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase = 3;
    for (int i = 0; i < 50; i++) begin
      pending_values.push_back(random_value());
    end

    while (pending_values.size() > 0 || in_valid) @(posedge clk);
    while (expected_text.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
